@@ rtl/owse_pkg.sv @@
// ----------------------------------------------------------------------------
// owse_pkg
// Shared types and constants for the 1-Wire search ROM engine.
// ----------------------------------------------------------------------------
`default_nettype none

package owse_pkg;

   localparam int ROM_BITS = 64;
   localparam int POS_W    = 7;
   localparam int IDX_W    = 6;
   localparam int FAM_W    = 4;

   // first position past the ROM; reaching it ends the pass
   localparam logic [POS_W-1:0] ROM_BITS_END = 7'd65;
   // zero picks below this position fall inside the family byte
   localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;
   localparam logic [POS_W-1:0] POS_FIRST    = 7'd1;

   typedef enum logic [1:0] {
      KIND_BEGIN = 2'd0,
      KIND_BIT   = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_SEND   = 3'd0,
      STATUS_BIT    = 3'd1,
      STATUS_FOUND  = 3'd2,
      STATUS_DONE   = 3'd3,
      STATUS_IGNORE = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       presence;
      logic       id_bit;
      logic       complement_bit;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic                write_dir;
      logic [ROM_BITS-1:0] rom;
      logic                last_device;
      logic [FAM_W-1:0]    family_discrepancy;
   } rsp_type;

   typedef struct packed {
      logic [ROM_BITS-1:0] rom_image;
      logic [POS_W-1:0]    bit_position;
      logic [POS_W-1:0]    last_zero_pick;
      logic [POS_W-1:0]    last_discrepancy_pos;
      logic [FAM_W-1:0]    family_discrepancy_pos;
      logic                last_device_seen;
      logic                pass_active;
   } search_state_type;

endpackage

`default_nettype wire

@@ rtl/owse_req_if.sv @@
// ----------------------------------------------------------------------------
// owse_req_if
// Input channel of the search ROM engine: valid/ready plus one item word.
// ----------------------------------------------------------------------------
`default_nettype none

interface owse_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       presence;
   logic       id_bit;
   logic       complement_bit;

   modport source (output valid, kind, presence, id_bit, complement_bit, input ready);
   modport sink   (input valid, kind, presence, id_bit, complement_bit, output ready);
endinterface

`default_nettype wire

@@ rtl/owse_rsp_if.sv @@
// ----------------------------------------------------------------------------
// owse_rsp_if
// Result channel of the search ROM engine: valid/ready plus one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface owse_rsp_if;
   logic                           valid;
   logic                           ready;
   owse_pkg::status_type           status;
   logic                           write_dir;
   logic [owse_pkg::ROM_BITS-1:0]  rom;
   logic                           last_device;
   logic [owse_pkg::FAM_W-1:0]     family_discrepancy;

   modport source (output valid, status, write_dir, rom, last_device, family_discrepancy,
                   input ready);
   modport sink   (input valid, status, write_dir, rom, last_device, family_discrepancy,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/owse_step.sv @@
// ----------------------------------------------------------------------------
// owse_step
// Single-word search step: next search state and result word from the
// current state and one item.
// ----------------------------------------------------------------------------
`default_nettype none

module owse_step (
   input  owse_pkg::req_type          item,
   input  owse_pkg::search_state_type cur,
   output owse_pkg::search_state_type nxt,
   output owse_pkg::rsp_type          res
);

   logic [owse_pkg::POS_W-1:0] pos;
   logic [owse_pkg::IDX_W-1:0] idx;
   logic                       rom_bit;
   logic                       dir;
   logic                       both_zero;

   function automatic owse_pkg::search_state_type clear_search(
      input owse_pkg::search_state_type s
   );
      owse_pkg::search_state_type r;
      r = s;
      r.last_discrepancy_pos   = '0;
      r.family_discrepancy_pos = '0;
      r.last_device_seen       = 1'b0;
      r.pass_active            = 1'b0;
      return r;
   endfunction

   assign pos       = cur.bit_position;
   assign idx       = owse_pkg::IDX_W'(pos - owse_pkg::POS_FIRST);
   assign rom_bit   = cur.rom_image[idx];
   assign both_zero = (item.id_bit == item.complement_bit);

   // agreed bit wins; else replay below last discrepancy, 1 at it, 0 past it
   always_comb begin
      if (!both_zero) begin
         dir = item.id_bit;
      end else if (pos < cur.last_discrepancy_pos) begin
         dir = rom_bit;
      end else begin
         dir = (pos == cur.last_discrepancy_pos);
      end
   end

   always_comb begin
      nxt        = cur;
      res        = '0;
      res.status = owse_pkg::STATUS_IGNORE;
      unique case (item.kind)
         owse_pkg::KIND_BEGIN: begin
            if (cur.last_device_seen || !item.presence) begin
               nxt        = clear_search(cur);
               res.status = owse_pkg::STATUS_DONE;
            end else begin
               nxt.pass_active    = 1'b1;
               nxt.bit_position   = owse_pkg::POS_FIRST;
               nxt.last_zero_pick = '0;
               res.status         = owse_pkg::STATUS_SEND;
            end
         end
         owse_pkg::KIND_BIT: begin
            if (cur.pass_active) begin
               if (item.id_bit && item.complement_bit) begin
                  // nobody answered: drop the search, keep the partial ROM
                  nxt        = clear_search(cur);
                  res.status = owse_pkg::STATUS_DONE;
               end else begin
                  nxt.rom_image[idx] = dir;
                  if (both_zero && !dir) begin
                     nxt.last_zero_pick = pos;
                     if (pos < owse_pkg::FAMILY_LIMIT) begin
                        nxt.family_discrepancy_pos = owse_pkg::FAM_W'(pos);
                     end
                  end
                  nxt.bit_position = owse_pkg::POS_W'(pos + owse_pkg::POS_FIRST);
                  res.write_dir    = dir;
                  res.status       = owse_pkg::STATUS_BIT;
                  if (nxt.bit_position >= owse_pkg::ROM_BITS_END) begin
                     nxt.pass_active          = 1'b0;
                     nxt.last_discrepancy_pos = nxt.last_zero_pick;
                     if (nxt.last_zero_pick == '0) begin
                        nxt.last_device_seen = 1'b1;
                     end
                     if (nxt.rom_image[7:0] == 8'd0) begin
                        nxt        = clear_search(nxt);
                        res.status = owse_pkg::STATUS_DONE;
                     end else begin
                        res.status             = owse_pkg::STATUS_FOUND;
                        res.rom                = nxt.rom_image;
                        res.last_device        = nxt.last_device_seen;
                        res.family_discrepancy = nxt.family_discrepancy_pos;
                     end
                  end
               end
            end
         end
         owse_pkg::KIND_CLEAR: begin
            nxt                = clear_search(cur);
            nxt.rom_image      = '0;
            nxt.bit_position   = owse_pkg::POS_FIRST;
            nxt.last_zero_pick = '0;
            res.status         = owse_pkg::STATUS_DONE;
         end
         default: begin
            res.status = owse_pkg::STATUS_IGNORE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/owse_outq.sv @@
// ----------------------------------------------------------------------------
// owse_outq
// Two-entry result queue: the result register plus a skid entry, so the
// engine keeps taking words while one result waits on the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module owse_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  owse_pkg::rsp_type in_data,
   owse_rsp_if.source        rsp_bus
);

   owse_pkg::rsp_type head_ff;
   owse_pkg::rsp_type tail_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign pop      = (count_ff != 2'd0) && rsp_bus.ready;

   always_comb begin
      case (count_ff)
         2'd0:    count_in = push ? 2'd1 : 2'd0;
         2'd1:    count_in = (push && !pop) ? 2'd2 : ((pop && !push) ? 2'd0 : 2'd1);
         2'd2:    count_in = pop ? 2'd1 : 2'd2;
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         // advance the skid entry, or refill straight from the engine
         head_ff <= (count_ff == 2'd2) ? tail_ff : in_data;
      end else if (push && count_ff == 2'd0) begin
         head_ff <= in_data;
      end
      if (push && count_ff == 2'd1 && !pop) begin
         tail_ff <= in_data;
      end
   end

   assign rsp_bus.valid              = (count_ff != 2'd0);
   assign rsp_bus.status             = head_ff.status;
   assign rsp_bus.write_dir          = head_ff.write_dir;
   assign rsp_bus.rom                = head_ff.rom;
   assign rsp_bus.last_device        = head_ff.last_device;
   assign rsp_bus.family_discrepancy = head_ff.family_discrepancy;

endmodule

`default_nettype wire

@@ rtl/onewire_rom_search_engine_unit.sv @@
// ----------------------------------------------------------------------------
// onewire_rom_search_engine_unit
// Search ROM engine for a 1-Wire bus master: walks the 64 ROM bit
// positions one bit pair per word and reports each found device.
// ----------------------------------------------------------------------------
//   channel   direction   handshake          word
//   req_bus   in          valid/ready        kind, presence, id_bit, complement_bit
//   rsp_bus   out         valid/ready        status, write_dir, rom, last_device,
//                                            family_discrepancy
//
// One word per cycle while the result queue has room; a result passes
// through the input register, then the result queue, before it is offered.
// The search state is updated in the same cycle a word leaves the input
// register, so each word sees the state left by the one before.
// Reset is synchronous and restores the whole search state.
// The two-entry result queue lets the input keep flowing while a result
// waits; the input stalls only when both queue entries and the input
// register are held.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search_engine_unit (
   input  logic       clock,
   input  logic       reset,
   owse_req_if.sink   req_bus,
   owse_rsp_if.source rsp_bus
);

   owse_pkg::req_type          item_ff;
   logic                       item_valid_ff;
   logic                       item_valid_in;
   owse_pkg::search_state_type state_ff;
   owse_pkg::search_state_type state_in;
   owse_pkg::rsp_type          result;
   logic                       q_ready;
   logic                       advance;
   logic                       req_accept;

   assign advance       = item_valid_ff && q_ready;
   assign req_bus.ready = !item_valid_ff || q_ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign item_valid_in = req_accept || (item_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.kind           <= req_bus.kind;
         item_ff.presence       <= req_bus.presence;
         item_ff.id_bit         <= req_bus.id_bit;
         item_ff.complement_bit <= req_bus.complement_bit;
      end
   end

   owse_step u_step (
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{rom_image:              '0,
                       bit_position:           owse_pkg::POS_FIRST,
                       last_zero_pick:         '0,
                       last_discrepancy_pos:   '0,
                       family_discrepancy_pos: '0,
                       last_device_seen:       1'b0,
                       pass_active:            1'b0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   owse_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (item_valid_ff),
      .in_ready (q_ready),
      .in_data  (result),
      .rsp_bus  (rsp_bus)
   );

   // an active pass always sits on a ROM position
   a_pass_position: assert property (@(posedge clock) disable iff (reset)
      state_ff.pass_active |->
         (state_ff.bit_position >= owse_pkg::POS_FIRST &&
          state_ff.bit_position < owse_pkg::ROM_BITS_END))
      else $error("active pass outside ROM positions");

   a_family_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.family_discrepancy_pos < 4'(owse_pkg::FAMILY_LIMIT))
      else $error("family discrepancy beyond family byte");

   a_found_family: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == owse_pkg::STATUS_FOUND) |->
         (rsp_bus.rom[7:0] != 8'd0))
      else $error("device reported with zero family byte");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != owse_pkg::STATUS_FOUND) |->
         (rsp_bus.rom == '0 && !rsp_bus.last_device && rsp_bus.family_discrepancy == '0))
      else $error("device fields set without a found device");

   // a pass ended by a bit word (not an abort) leaves the position one past the ROM
   a_pass_end: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff.pass_active) && $past(advance) &&
         $past(item_ff.kind) == owse_pkg::KIND_BIT && !$past(item_ff.id_bit && item_ff.complement_bit)
      |-> state_ff.bit_position == owse_pkg::ROM_BITS_END)
      else $error("pass ended before the last ROM bit");

endmodule

`default_nettype wire

@@ sim/tb_onewire_rom_search_engine_unit.sv @@
// ----------------------------------------------------------------------------
// tb_onewire_rom_search_engine_unit
// Self-checking bench for the search ROM engine. A bus model of zero to four
// devices answers each bit pair from the devices still on the search path,
// so most words form whole enumerations. Stray words, aborts and restarts
// are mixed in. Every accepted word is run through a local model of the
// engine, and each result word is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_onewire_rom_search_engine_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_RESERVED = 2'd3;
   localparam int WORD_TARGET  = 700;
   localparam int QUIET_WORDS  = 80;
   localparam int HOLD_AT      = 250;
   localparam int HOLD_CYCLES  = 48;
   localparam int TAIL_CYCLES  = 10;
   localparam int MAX_DEVICES  = 4;

   typedef struct {
      owse_pkg::req_type word;
      bit                drain_first;
   } bus_word_type;

   logic clock;
   logic reset;

   owse_req_if req_bus ();
   owse_rsp_if rsp_bus ();

   onewire_rom_search_engine_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bus_word_type               words_to_send[$];
   owse_pkg::rsp_type          expected_rsp[$];
   owse_pkg::search_state_type engine_state;
   owse_pkg::search_state_type plan_state;

   logic [63:0] bus_rom[MAX_DEVICES];
   int          mismatch_count = 0;
   int          accepted_count = 0;
   bit          req_taken = 1'b0;
   bit          quiet = 1'b0;
   int          req_idle_left = 0;
   int          rsp_idle_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic owse_pkg::search_state_type search_after_reset();
      owse_pkg::search_state_type s;
      s = '0;
      s.bit_position = owse_pkg::POS_FIRST;
      return s;
   endfunction

   function automatic owse_pkg::search_state_type drop_search(
      input owse_pkg::search_state_type s
   );
      owse_pkg::search_state_type d;
      d = s;
      d.last_discrepancy_pos   = '0;
      d.family_discrepancy_pos = '0;
      d.last_device_seen       = 1'b0;
      d.pass_active            = 1'b0;
      return d;
   endfunction

   // one engine step: the result for word rq, with st advanced past it
   function automatic owse_pkg::rsp_type search_step(
      inout owse_pkg::search_state_type st,
      input owse_pkg::req_type          rq
   );
      owse_pkg::rsp_type          r;
      logic [owse_pkg::POS_W-1:0] pos;
      logic [owse_pkg::POS_W-1:0] pos_less;
      logic [5:0]                 idx;
      logic                       dir;
      r = '0;
      r.status = owse_pkg::STATUS_IGNORE;
      case (rq.kind)
         owse_pkg::KIND_BEGIN: begin
            if (st.last_device_seen || !rq.presence) begin
               st = drop_search(st);
               r.status = owse_pkg::STATUS_DONE;
            end else begin
               st.pass_active    = 1'b1;
               st.bit_position   = owse_pkg::POS_FIRST;
               st.last_zero_pick = '0;
               r.status = owse_pkg::STATUS_SEND;
            end
         end
         owse_pkg::KIND_BIT: begin
            if (st.pass_active) begin
               if (rq.id_bit && rq.complement_bit) begin
                  // nobody answered: abort the pass
                  st = drop_search(st);
                  r.status = owse_pkg::STATUS_DONE;
               end else begin
                  pos      = st.bit_position;
                  pos_less = pos - owse_pkg::POS_FIRST;
                  idx      = pos_less[5:0];
                  if (rq.id_bit != rq.complement_bit) begin
                     dir = rq.id_bit;
                  end else begin
                     if (pos < st.last_discrepancy_pos)
                        dir = st.rom_image[idx];
                     else
                        dir = (pos == st.last_discrepancy_pos);
                     if (!dir) begin
                        st.last_zero_pick = pos;
                        if (pos < owse_pkg::FAMILY_LIMIT)
                           st.family_discrepancy_pos = pos[owse_pkg::FAM_W-1:0];
                     end
                  end
                  st.rom_image[idx] = dir;
                  r.write_dir       = dir;
                  r.status          = owse_pkg::STATUS_BIT;
                  st.bit_position   = pos + owse_pkg::POS_FIRST;
                  if (st.bit_position >= owse_pkg::ROM_BITS_END) begin
                     st.pass_active          = 1'b0;
                     st.last_discrepancy_pos = st.last_zero_pick;
                     if (st.last_discrepancy_pos == '0)
                        st.last_device_seen = 1'b1;
                     // zero family byte fails the pass; write_dir keeps its value
                     if (st.rom_image[7:0] == 8'h00) begin
                        st = drop_search(st);
                        r.status = owse_pkg::STATUS_DONE;
                     end else begin
                        r.status             = owse_pkg::STATUS_FOUND;
                        r.rom                = st.rom_image;
                        r.last_device        = st.last_device_seen;
                        r.family_discrepancy = st.family_discrepancy_pos;
                     end
                  end
               end
            end
         end
         owse_pkg::KIND_CLEAR: begin
            st = drop_search(st);
            st.rom_image      = '0;
            st.bit_position   = owse_pkg::POS_FIRST;
            st.last_zero_pick = '0;
            r.status = owse_pkg::STATUS_DONE;
         end
         default: r.status = owse_pkg::STATUS_IGNORE;
      endcase
      return r;
   endfunction

   task automatic queue_word(input logic [1:0] kind, input logic pres, input logic idb,
                             input logic cmpb, input bit drain,
                             output owse_pkg::rsp_type r);
      bus_word_type e;
      e.word.kind           = kind;
      e.word.presence       = pres;
      e.word.id_bit         = idb;
      e.word.complement_bit = cmpb;
      e.drain_first         = drain;
      r = search_step(plan_state, e.word);
      words_to_send.push_back(e);
   endtask

   task automatic queue_stray_word(output owse_pkg::rsp_type r, output logic [1:0] kind);
      kind = 2'($urandom_range(0, 3));
      queue_word(kind, 1'($urandom), 1'($urandom), 1'($urandom), 1'b0, r);
   endtask

   task automatic make_bus(output int n);
      logic [63:0] base;
      logic [63:0] dev;
      bit          clash;
      int          pick;
      n    = $urandom_range(0, MAX_DEVICES);
      pick = $urandom_range(0, 9);
      base = {$urandom, $urandom};
      if (pick == 0)
         base = '1;
      else if (pick == 1)
         base[7:0] = 8'h00;
      for (int i = 0; i < n; i++) begin
         if (i == 0) begin
            bus_rom[0] = base;
         end else begin
            do begin
               dev = base;
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(0, 1) == 0)
                     dev[$urandom_range(0, 7)] ^= 1'b1;
                  else
                     dev[$urandom_range(0, 63)] ^= 1'b1;
               end
               clash = 1'b0;
               for (int j = 0; j < i; j++)
                  if (bus_rom[j] == dev)
                     clash = 1'b1;
            end while (clash);
            bus_rom[i] = dev;
         end
      end
   endtask

   // walk one pass: bus answers wired-AND of the devices still on the path
   task automatic run_pass(input int n);
      logic [MAX_DEVICES-1:0]     on_path;
      logic [MAX_DEVICES-1:0]     all_devs;
      logic [owse_pkg::POS_W-1:0] pos_less;
      logic [5:0]                 idx;
      logic                       idb;
      logic                       cmpb;
      logic [1:0]                 kind;
      owse_pkg::rsp_type          r;
      all_devs = '0;
      for (int i = 0; i < n; i++)
         all_devs[i] = 1'b1;
      on_path = all_devs;
      while (plan_state.pass_active) begin
         pos_less = plan_state.bit_position - owse_pkg::POS_FIRST;
         idx      = pos_less[5:0];
         if ($urandom_range(0, 79) == 0) begin
            queue_stray_word(r, kind);
            if (kind == owse_pkg::KIND_BEGIN && r.status == owse_pkg::STATUS_SEND)
               on_path = all_devs;
         end else begin
            idb  = 1'b1;
            cmpb = 1'b1;
            for (int i = 0; i < n; i++)
               if (on_path[i]) begin
                  if (bus_rom[i][idx])
                     cmpb = 1'b0;
                  else
                     idb = 1'b0;
               end
            queue_word(owse_pkg::KIND_BIT, 1'($urandom), idb, cmpb, 1'b0, r);
         end
         if (r.status == owse_pkg::STATUS_BIT || r.status == owse_pkg::STATUS_FOUND)
            for (int i = 0; i < n; i++)
               if (bus_rom[i][idx] != r.write_dir)
                  on_path[i] = 1'b0;
      end
   endtask

   task automatic fill_words();
      owse_pkg::rsp_type r;
      logic [1:0]        kind;
      int                n;
      int                passes;
      bit                first;
      // stray words, aborts, restarts and clears
      queue_word(owse_pkg::KIND_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0, r);
      queue_word(owse_pkg::KIND_BIT,   1'b0, 1'b0, 1'b1, 1'b0, r);
      queue_word(KIND_RESERVED,        1'b1, 1'b1, 1'b1, 1'b0, r);
      queue_word(owse_pkg::KIND_BEGIN, 1'b0, 1'b0, 1'b0, 1'b0, r);
      queue_word(owse_pkg::KIND_BEGIN, 1'b1, 1'b0, 1'b0, 1'b0, r);
      queue_word(owse_pkg::KIND_BIT,   1'b0, 1'b1, 1'b0, 1'b0, r);
      queue_word(owse_pkg::KIND_BIT,   1'b1, 1'b0, 1'b1, 1'b0, r);
      queue_word(owse_pkg::KIND_BIT,   1'b0, 1'b0, 1'b0, 1'b0, r);
      queue_word(owse_pkg::KIND_BEGIN, 1'b1, 1'b1, 1'b1, 1'b0, r);
      queue_word(owse_pkg::KIND_BIT,   1'b0, 1'b0, 1'b0, 1'b0, r);
      queue_word(owse_pkg::KIND_BIT,   1'b0, 1'b1, 1'b1, 1'b0, r);
      queue_word(owse_pkg::KIND_BIT,   1'b0, 1'b0, 1'b0, 1'b0, r);
      queue_word(KIND_RESERVED,        1'b0, 1'b0, 1'b0, 1'b0, r);
      queue_word(owse_pkg::KIND_CLEAR, 1'b1, 1'b1, 1'b1, 1'b0, r);
      first = 1'b1;
      while (words_to_send.size() < WORD_TARGET) begin
         make_bus(n);
         if ($urandom_range(0, 1) == 0)
            queue_word(owse_pkg::KIND_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom),
                       first, r);
         else
            queue_word(owse_pkg::KIND_BEGIN, 1'b0, 1'b0, 1'b0, first, r);
         passes = 0;
         while (passes < n + 2 && words_to_send.size() < WORD_TARGET) begin
            queue_word(owse_pkg::KIND_BEGIN, n > 0, 1'($urandom), 1'($urandom),
                       $urandom_range(0, 9) == 0, r);
            if (r.status != owse_pkg::STATUS_SEND)
               break;
            run_pass(n);
            passes++;
         end
         repeat ($urandom_range(0, 3))
            queue_stray_word(r, kind);
         first = 1'b0;
      end
   endtask

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
   endtask

   // sender: hold an offered word until taken
   always @(negedge clock) begin
      quiet = (words_to_send.size() < QUIET_WORDS);
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_taken) begin
         req_bus.valid <= 1'b1;
      end else if (req_idle_left > 0) begin
         req_bus.valid <= 1'b0;
         req_idle_left--;
      end else if (words_to_send.size() == 0) begin
         req_bus.valid <= 1'b0;
      end else if (words_to_send[0].drain_first && expected_rsp.size() != 0) begin
         req_bus.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         req_idle_left = $urandom_range(0, 2);
      end else begin
         req_bus.valid          <= 1'b1;
         req_bus.kind           <= words_to_send[0].word.kind;
         req_bus.presence       <= words_to_send[0].word.presence;
         req_bus.id_bit         <= words_to_send[0].word.id_bit;
         req_bus.complement_bit <= words_to_send[0].word.complement_bit;
         void'(words_to_send.pop_front());
      end
   end

   // receiver: random bursts, with one long hold-off after HOLD_AT accepted words
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         rsp_bus.ready <= 1'b0;
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (rsp_idle_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_idle_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_idle_left = $urandom_range(0, 2);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      owse_pkg::req_type w;
      owse_pkg::rsp_type want;
      req_taken = req_bus.valid && req_bus.ready && !reset;
      if (req_taken) begin
         w.kind           = req_bus.kind;
         w.presence       = req_bus.presence;
         w.id_bit         = req_bus.id_bit;
         w.complement_bit = req_bus.complement_bit;
         expected_rsp.push_back(search_step(engine_state, w));
         accepted_count++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result word with nothing pending: status %0d", rsp_bus.status);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_bus.status !== want.status)
               note_mismatch("status", want.status, rsp_bus.status);
            if (rsp_bus.write_dir !== want.write_dir)
               note_mismatch("write_dir", want.write_dir, rsp_bus.write_dir);
            if (rsp_bus.rom !== want.rom)
               note_mismatch("rom", want.rom, rsp_bus.rom);
            if (rsp_bus.last_device !== want.last_device)
               note_mismatch("last_device", want.last_device, rsp_bus.last_device);
            if (rsp_bus.family_discrepancy !== want.family_discrepancy)
               note_mismatch("family_discrepancy", want.family_discrepancy,
                             rsp_bus.family_discrepancy);
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.kind           = owse_pkg::KIND_BEGIN;
      req_bus.presence       = 1'b0;
      req_bus.id_bit         = 1'b0;
      req_bus.complement_bit = 1'b0;
      rsp_bus.ready          = 1'b0;
      engine_state           = search_after_reset();
      plan_state             = search_after_reset();
      fill_words();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (words_to_send.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/owse_pkg.sv
rtl/owse_req_if.sv
rtl/owse_rsp_if.sv
rtl/owse_step.sv
rtl/owse_outq.sv
rtl/onewire_rom_search_engine_unit.sv
sim/tb_onewire_rom_search_engine_unit.sv
